// File: design/bole_pkg.sv
`timescale 1ns / 1ps
// Package for the bounded ordered list engine.
// Holds the command, status, state and cell control types and the default capacity.
// It depends on nothing else.
package bole_pkg;

  localparam int DEFAULT_CAPACITY = 16;

  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 6;
  localparam int STATUS_W   = 2;
  localparam int INDEX_OUT_W  = 4;
  localparam int LENGTH_OUT_W = 5;

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_RM_HEAD  = 3'd3,
    CMD_RM_TAIL  = 3'd4,
    CMD_RM_POS   = 3'd5,
    CMD_SEARCH   = 3'd6,
    CMD_CLEAR    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // What every cell of the row does on a clock edge.
  typedef enum logic [2:0] {
    CELL_HOLD      = 3'd0,
    CELL_INSERT    = 3'd1,
    CELL_REMOVE    = 3'd2,
    CELL_COMPARE   = 3'd3,
    CELL_SHIFT_HIT = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctl_t;

endpackage

// File: design/bole_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the bounded ordered list engine.
// Depends on bole_pkg for the field widths.
interface bole_cmd_if;
  logic                                      valid;
  logic                                      ready;
  logic [2:0]                                cmd;
  logic signed [bole_pkg::VALUE_W-1:0]       value;
  logic signed [bole_pkg::POSITION_W-1:0]    position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface bole_rsp_if;
  logic                                      valid;
  logic                                      ready;
  logic [bole_pkg::STATUS_W-1:0]             status;
  logic                                      found;
  logic [bole_pkg::INDEX_OUT_W-1:0]          found_index;
  logic [bole_pkg::LENGTH_OUT_W-1:0]         length;

  modport source (output valid, output status, output found, output found_index,
                  output length, input ready);
  modport sink   (input valid, input status, input found, input found_index,
                  input length, output ready);
endinterface

// File: design/bole_cell.sv
`timescale 1ns / 1ps
// One cell of the list row: holds one entry and its search hit flag.
// Depends on bole_pkg for the cell control struct.
module bole_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bole_pkg::cell_ctl_t                  ctl,
  input  logic [CNT_W-1:0]                     at,
  input  logic [CNT_W-1:0]                     count,
  input  logic signed [bole_pkg::VALUE_W-1:0]  prev_data,
  input  logic signed [bole_pkg::VALUE_W-1:0]  next_data,
  input  logic                                 next_hit,
  output logic signed [bole_pkg::VALUE_W-1:0]  data,
  output logic                                 hit
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic signed [bole_pkg::VALUE_W-1:0] data_r, data_nxt;
  logic                                hit_r, hit_nxt;

  always_comb begin
    data_nxt = data_r;
    hit_nxt  = hit_r;
    unique case (ctl.op)
      bole_pkg::CELL_INSERT: begin
        // Cells behind the insertion point take their left neighbor's entry.
        if (MY_IDX > at) begin
          data_nxt = prev_data;
        end else if (MY_IDX == at) begin
          data_nxt = ctl.value;
        end
      end
      bole_pkg::CELL_REMOVE: begin
        if (MY_IDX >= at) begin
          data_nxt = next_data;
        end
      end
      bole_pkg::CELL_COMPARE: begin
        hit_nxt = (data_r == ctl.value) && (MY_IDX < count);
      end
      bole_pkg::CELL_SHIFT_HIT: begin
        hit_nxt = next_hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

// File: design/bounded_ordered_list_engine_top.sv
`timescale 1ns / 1ps
// Bounded ordered list engine, top level. Depends on bole_pkg, bole_ifs and bole_cell.
// An insert, remove or clear word gives its result word in the cycle after it is taken;
// a search compares in all cells, then walks the hit flags one cell per cycle until a hit
// or the last live cell's flag reaches cell zero, and holds off new commands meanwhile.
// Throughput: one non-search command per cycle while the result side takes each word.
// Reset (synchronous, rst_n low) empties the list; entry contents are not cleared.
module bounded_ordered_list_engine_top #(
  parameter int LIST_CAPACITY = bole_pkg::DEFAULT_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  bole_cmd_if.sink   in_cmd,
  bole_rsp_if.source out_rsp
);

  // Count width holds the capacity itself; comparisons against the position run
  // at a width that also holds the five magnitude bits of a positive position.
  localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
  localparam int CMP_W = (CNT_W > bole_pkg::POSITION_W) ? CNT_W : bole_pkg::POSITION_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(LIST_CAPACITY);

  // Control state.
  bole_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;

  // Result register. The next command gets in during the cycle in which the
  // current result word is taken; a result word that waits holds the input off.
  logic                             out_valid_r, out_valid_nxt;
  bole_pkg::status_t                out_status_r, out_status_nxt;
  logic                             out_found_r, out_found_nxt;
  logic [bole_pkg::INDEX_OUT_W-1:0] out_index_r, out_index_nxt;
  logic [bole_pkg::LENGTH_OUT_W-1:0] out_length_r, out_length_nxt;

  // Row of cells.
  bole_pkg::cell_ctl_t                 cell_ctl;
  logic [CNT_W-1:0]                    cell_at;
  logic signed [bole_pkg::VALUE_W-1:0] cell_data [LIST_CAPACITY];
  logic                                cell_hit  [LIST_CAPACITY];

  logic              in_take;
  logic              out_take;
  bole_pkg::cmd_t    cmd;
  logic              list_full;
  logic              list_empty;
  logic              pos_neg;
  logic [CMP_W-1:0]  pos_u;
  logic [CMP_W-1:0]  count_cmp;
  logic [CNT_W-1:0]  pos_cnt;
  logic              scan_last;

  assign out_take   = out_valid_r && out_rsp.ready;
  assign in_cmd.ready = (state_r == bole_pkg::ST_IDLE) && (!out_valid_r || out_rsp.ready);
  assign in_take    = in_cmd.valid && in_cmd.ready;

  assign cmd        = bole_pkg::cmd_t'(in_cmd.cmd);
  assign list_full  = (count_r >= CAP_CNT);
  assign list_empty = (count_r == '0);
  assign pos_neg    = in_cmd.position[bole_pkg::POSITION_W-1];
  assign pos_u      = CMP_W'(in_cmd.position[bole_pkg::POSITION_W-2:0]);
  assign count_cmp  = CMP_W'(count_r);
  // Only used where pos_u is at most the count, so it fits the count width.
  assign pos_cnt    = CNT_W'(pos_u);
  // The scan ends once the last live cell's hit flag has reached cell zero.
  assign scan_last  = ((CMP_W + 1)'(scan_r) + (CMP_W + 1)'(1)) >= (CMP_W + 1)'(count_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bole_pkg::ST_IDLE: begin
        if (in_take && (cmd == bole_pkg::CMD_SEARCH)) begin
          state_nxt = bole_pkg::ST_SCAN;
        end
      end
      bole_pkg::ST_SCAN: begin
        if (cell_hit[0] || scan_last) begin
          state_nxt = bole_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bole_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: cell commands, count update and the result word.
  always_comb begin
    cell_ctl.op    = bole_pkg::CELL_HOLD;
    cell_ctl.value = in_cmd.value;
    cell_at        = '0;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    out_valid_nxt  = out_valid_r && !out_take;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_index_nxt  = out_index_r;
    out_length_nxt = out_length_r;

    unique case (state_r)
      bole_pkg::ST_IDLE: begin
        if (in_take) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bole_pkg::STAT_DONE;
          out_found_nxt  = 1'b0;
          out_index_nxt  = '0;
          unique case (cmd)
            bole_pkg::CMD_INS_HEAD, bole_pkg::CMD_INS_TAIL, bole_pkg::CMD_INS_POS: begin
              if (list_full) begin
                out_status_nxt = bole_pkg::STAT_FULL;
              end else begin
                cell_ctl.op = bole_pkg::CELL_INSERT;
                count_nxt   = count_r + CNT_W'(1);
                if (cmd == bole_pkg::CMD_INS_TAIL) begin
                  cell_at = count_r;
                end else if (cmd == bole_pkg::CMD_INS_POS && !pos_neg && !list_empty
                             && pos_u != '0) begin
                  // A position past the end lands at the tail.
                  cell_at = (pos_u > count_cmp) ? count_r : pos_cnt;
                end else begin
                  cell_at = '0;
                end
              end
            end
            bole_pkg::CMD_RM_HEAD: begin
              if (list_empty) begin
                out_status_nxt = bole_pkg::STAT_EMPTY;
              end else begin
                cell_ctl.op = bole_pkg::CELL_REMOVE;
                cell_at     = '0;
                count_nxt   = count_r - CNT_W'(1);
              end
            end
            bole_pkg::CMD_RM_TAIL: begin
              if (list_empty) begin
                out_status_nxt = bole_pkg::STAT_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            bole_pkg::CMD_RM_POS: begin
              if (list_empty) begin
                out_status_nxt = bole_pkg::STAT_EMPTY;
              end else if (pos_neg || pos_u >= count_cmp) begin
                out_status_nxt = bole_pkg::STAT_MISS;
              end else begin
                cell_ctl.op = bole_pkg::CELL_REMOVE;
                cell_at     = pos_cnt;
                count_nxt   = count_r - CNT_W'(1);
              end
            end
            bole_pkg::CMD_SEARCH: begin
              // Every cell compares at once; the result comes out of the scan.
              cell_ctl.op   = bole_pkg::CELL_COMPARE;
              out_valid_nxt = 1'b0;
              scan_nxt      = '0;
            end
            default: begin
              count_nxt = '0;
            end
          endcase
          out_length_nxt = bole_pkg::LENGTH_OUT_W'(count_nxt);
        end
      end
      bole_pkg::ST_SCAN: begin
        if (cell_hit[0]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bole_pkg::STAT_DONE;
          out_found_nxt  = 1'b1;
          out_index_nxt  = bole_pkg::INDEX_OUT_W'(scan_r);
          out_length_nxt = bole_pkg::LENGTH_OUT_W'(count_r);
        end else if (scan_last) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bole_pkg::STAT_MISS;
          out_found_nxt  = 1'b0;
          out_index_nxt  = '0;
          out_length_nxt = bole_pkg::LENGTH_OUT_W'(count_r);
        end else begin
          cell_ctl.op = bole_pkg::CELL_SHIFT_HIT;
          scan_nxt    = scan_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bole_pkg::ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_index_r  <= out_index_nxt;
    out_length_r <= out_length_nxt;
  end

  // The cell row. Each cell sees its two neighbors; the head sees the command value on its
  // left, and the tail sees its own entry and a clear hit flag on its right.
  for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
    logic signed [bole_pkg::VALUE_W-1:0] prev_d;
    logic signed [bole_pkg::VALUE_W-1:0] next_d;
    logic                                next_h;

    if (g == 0) begin : g_head
      assign prev_d = in_cmd.value;
    end else begin : g_mid_prev
      assign prev_d = cell_data[g-1];
    end

    if (g == LIST_CAPACITY - 1) begin : g_tail
      assign next_d = cell_data[g];
      assign next_h = 1'b0;
    end else begin : g_mid_next
      assign next_d = cell_data[g+1];
      assign next_h = cell_hit[g+1];
    end

    bole_cell #(
      .INDEX (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .at        (cell_at),
      .count     (count_r),
      .prev_data (prev_d),
      .next_data (next_d),
      .next_hit  (next_h),
      .data      (cell_data[g]),
      .hit       (cell_hit[g])
    );
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.found       = out_found_r;
  assign out_rsp.found_index = out_index_r;
  assign out_rsp.length      = out_length_r;

  // The result register is always free while a search walks the row.
  a_scan_out_free : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bole_pkg::ST_SCAN) |-> !out_valid_r)
    else $error("result pending during search scan");

  // The count never exceeds the capacity.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count beyond capacity");

  // Every non-search command gives its result in the next cycle.
  a_direct_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && cmd != bole_pkg::CMD_SEARCH) |=> out_valid_r)
    else $error("result missing after command");

  // A search always goes through the scan.
  a_search_scan : assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && cmd == bole_pkg::CMD_SEARCH) |=> (state_r == bole_pkg::ST_SCAN))
    else $error("search did not start a scan");

  // A hit is only ever reported with a done status.
  a_found_done : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == bole_pkg::STAT_DONE))
    else $error("search hit with bad status");

endmodule

// File: test/bounded_ordered_list_engine_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded ordered list engine top level.
// Depends on bole_pkg, the bole_cmd_if / bole_rsp_if interfaces and the engine RTL.
module bounded_ordered_list_engine_top_tb;
  import bole_pkg::*;

  localparam int LIST_CAP = DEFAULT_CAPACITY;

  // A search scans at most the whole row, so the longest correct wait for one word
  // is a full scan; the tail wait and the watchdog are sized well beyond that.
  localparam int DRAIN_CYCLES       = 2 * LIST_CAP + 8;
  localparam int RESULT_HOLD_CYCLES = 120;
  localparam int WATCHDOG_LIMIT     = 4000;
  localparam int REPORT_LIMIT       = 10;

  localparam logic signed [VALUE_W-1:0]    VALUE_MOST_NEG = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0]    VALUE_MOST_POS = 32'sh7fff_ffff;
  localparam logic signed [POSITION_W-1:0] POS_MOST_NEG   = 6'sh20;
  localparam logic signed [POSITION_W-1:0] POS_MOST_POS   = 6'sh1f;

  // What one result word should carry.
  typedef struct packed {
    status_t                 status;
    logic                    found;
    logic [INDEX_OUT_W-1:0]  found_index;
    logic [LENGTH_OUT_W-1:0] length;
  } list_result_t;

  // Ready patterns that the result side cycles through.
  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_MOSTLY,
    RX_CADENCE
  } rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bole_cmd_if cmd_ch ();
  bole_rsp_if rsp_ch ();

  bounded_ordered_list_engine_top #(
    .LIST_CAPACITY(LIST_CAP)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (cmd_ch),
    .out_rsp(rsp_ch)
  );

  // 12 ns period: six high, six low.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Our own copy of the list: entries 0 .. list_len-1 are live, entry 0 is the head.
  logic signed [VALUE_W-1:0] list_mirror [LIST_CAP];
  int                        list_len = 0;

  // Result words still owed by the engine, oldest first.
  list_result_t pending_results[$];
  list_result_t oldest_result;
  int           mismatch_count = 0;
  int           result_words   = 0;
  int           stall_cycles   = 0;

  // Sender pacing state. A burst is a run of words offered back to back; between
  // bursts valid may drop for a random gap. gapless forces back to back.
  int burst_left        = 0;
  bit gapless           = 1'b0;
  // The random part steers the list length toward a target that drifts, so the
  // run spends time near empty, in the middle and at full capacity.
  int fill_target       = 0;
  int fill_target_left  = 0;
  // Set by a test to make the result side refuse words for a long stretch.
  bit hold_request      = 1'b0;

  // Applies one command to the mirror and returns the word the engine must answer.
  function automatic list_result_t apply_list_command(cmd_t op,
                                                      logic signed [VALUE_W-1:0] v,
                                                      logic signed [POSITION_W-1:0] p);
    list_result_t r;
    int at;
    int pos;
    int i;
    r.status      = STAT_DONE;
    r.found       = 1'b0;
    r.found_index = '0;
    pos           = p;
    case (op)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        if (list_len >= LIST_CAP) begin
          r.status = STAT_FULL;
        end else begin
          // A positional insert at or below zero, or into an empty list, lands on
          // the head; one past the end or further lands on the tail.
          if (op == CMD_INS_HEAD) at = 0;
          else if (op == CMD_INS_TAIL) at = list_len;
          else if (pos <= 0 || list_len == 0) at = 0;
          else at = (pos > list_len) ? list_len : pos;
          for (i = list_len; i > at; i--) list_mirror[i] = list_mirror[i-1];
          list_mirror[at] = v;
          list_len++;
        end
      end
      CMD_RM_HEAD: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (i = 0; i + 1 < list_len; i++) list_mirror[i] = list_mirror[i+1];
          list_len--;
        end
      end
      CMD_RM_TAIL: begin
        if (list_len == 0) r.status = STAT_EMPTY;
        else list_len--;
      end
      CMD_RM_POS: begin
        // An empty list wins over a bad position.
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else if (pos < 0 || pos >= list_len) begin
          r.status = STAT_MISS;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_mirror[i] = list_mirror[i+1];
          list_len--;
        end
      end
      CMD_SEARCH: begin
        // The first equal entry from the head wins.
        r.status = STAT_MISS;
        for (i = 0; i < list_len; i++) begin
          if (list_mirror[i] == v && !r.found) begin
            r.status      = STAT_DONE;
            r.found       = 1'b1;
            r.found_index = INDEX_OUT_W'(i);
          end
        end
      end
      default: list_len = 0;
    endcase
    r.length = LENGTH_OUT_W'(list_len);
    return r;
  endfunction

  // Values lean on the extremes and on a small pool, so that searches hit
  // duplicates and the first-match rule gets exercised.
  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return VALUE_MOST_NEG;
      1:       return VALUE_MOST_POS;
      2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Half the positions fall on or just past the live range, half anywhere in -32..31.
  function automatic logic signed [POSITION_W-1:0] random_position();
    if ($urandom_range(0, 1) == 0) return POSITION_W'($urandom_range(0, list_len + 1));
    return POSITION_W'($urandom_range(0, 63));
  endfunction

  // Moves to the falling edge where the next word goes out, inserting the idle
  // cycles between bursts on the way.
  task automatic next_slot();
    int gap;
    if (!gapless && burst_left == 0) begin
      case ($urandom_range(0, 5))
        0: begin
          gap        = 0;
          burst_left = $urandom_range(50, 150);
        end
        1: begin
          gap        = $urandom_range(10, 30);
          burst_left = $urandom_range(1, 24);
        end
        default: begin
          gap        = $urandom_range(1, 5);
          burst_left = $urandom_range(1, 24);
        end
      endcase
      repeat (gap) begin
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  // Offers one word, already at a falling edge, and holds it until it is taken.
  task automatic drive_word(cmd_t op, logic signed [VALUE_W-1:0] v,
                            logic signed [POSITION_W-1:0] p);
    cmd_ch.valid    <= 1'b1;
    cmd_ch.cmd      <= op;
    cmd_ch.value    <= v;
    cmd_ch.position <= p;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
  endtask

  task automatic send_word(cmd_t op, logic signed [VALUE_W-1:0] v,
                           logic signed [POSITION_W-1:0] p);
    next_slot();
    drive_word(op, v, p);
  endtask

  // Picks a command from the mirror at the falling edge, when it is up to date.
  // Most words are well-formed list traffic; a few percent are pure noise.
  task automatic send_random_word();
    cmd_t                         op;
    logic signed [VALUE_W-1:0]    v;
    logic signed [POSITION_W-1:0] p;
    int                           roll;
    next_slot();
    if (fill_target_left == 0) begin
      fill_target      = $urandom_range(0, LIST_CAP);
      fill_target_left = $urandom_range(20, 80);
    end
    fill_target_left--;
    roll = $urandom_range(0, 99);
    v    = random_value();
    p    = random_position();
    if (roll < 4) begin
      op = cmd_t'($urandom_range(0, 7));
      v  = $urandom;
      p  = POSITION_W'($urandom);
    end else if (roll < 6) begin
      op = CMD_CLEAR;
    end else if (roll < 26) begin
      op = CMD_SEARCH;
      if (list_len > 0 && $urandom_range(0, 3) != 0)
        v = list_mirror[$urandom_range(0, list_len - 1)];
    end else if (roll < ((list_len < fill_target) ? 76 : 46)) begin
      op = cmd_t'($urandom_range(CMD_INS_HEAD, CMD_INS_POS));
    end else begin
      op = cmd_t'($urandom_range(CMD_RM_HEAD, CMD_RM_POS));
    end
    drive_word(op, v, p);
  endtask

  // Drops valid and waits until every owed result word has come back.
  task automatic pause_for_results();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Removes, search and positional insert on an empty list, inserts at the extremes of value
  // and position, first-match search over duplicates, bad remove positions, and clear.
  task automatic test_edge_cases();
    send_word(CMD_RM_HEAD, 0, 0);
    send_word(CMD_RM_TAIL, 0, 0);
    send_word(CMD_RM_POS, 0, 0);
    send_word(CMD_SEARCH, 0, 0);
    // Positional insert into an empty list goes to the head whatever the position.
    send_word(CMD_INS_POS, 77, 5);
    send_word(CMD_INS_HEAD, VALUE_MOST_NEG, POS_MOST_POS);
    send_word(CMD_INS_TAIL, VALUE_MOST_POS, POS_MOST_NEG);
    send_word(CMD_INS_POS, -1, POS_MOST_NEG);
    send_word(CMD_INS_POS, 0, POS_MOST_POS);
    send_word(CMD_INS_POS, 77, 2);
    // A position equal to the length appends.
    send_word(CMD_INS_POS, 5, 6);
    send_word(CMD_SEARCH, VALUE_MOST_NEG, 0);
    send_word(CMD_SEARCH, 77, 0);
    send_word(CMD_SEARCH, 5, 0);
    send_word(CMD_SEARCH, 1234, 0);
    send_word(CMD_RM_POS, 0, -1);
    send_word(CMD_RM_POS, 0, 7);
    send_word(CMD_RM_POS, 0, POS_MOST_POS);
    send_word(CMD_RM_POS, 0, 3);
    send_word(CMD_RM_HEAD, 0, 0);
    send_word(CMD_RM_TAIL, 0, 0);
    send_word(CMD_CLEAR, 0, 0);
    send_word(CMD_SEARCH, 0, 0);
  endtask

  // Fills the list to capacity, checks that every kind of insert is then rejected,
  // runs the longest search, and empties the list past the bottom.
  task automatic test_full_list();
    send_word(CMD_CLEAR, 0, 0);
    repeat (LIST_CAP - 1)
      send_word(cmd_t'($urandom_range(CMD_INS_HEAD, CMD_INS_POS)), random_value(),
                POSITION_W'($urandom_range(0, 63)));
    send_word(CMD_INS_TAIL, 32'sh5eed_0f0f, 0);
    send_word(CMD_INS_HEAD, 1, 0);
    send_word(CMD_INS_TAIL, 2, 0);
    send_word(CMD_INS_POS, 3, 4);
    send_word(CMD_SEARCH, 32'sh5eed_0f0f, 0);
    send_word(CMD_SEARCH, 32'sh1234_5678, 0);
    repeat ((LIST_CAP + 2) / 2) begin
      send_word(CMD_RM_HEAD, 0, 0);
      send_word(CMD_RM_TAIL, 0, 0);
    end
  endtask

  // The result side refuses words for a long stretch while words keep coming,
  // so a result word waits and the engine has to stall its input.
  task automatic test_result_backpressure();
    hold_request = 1'b1;
    gapless      = 1'b1;
    repeat (40) send_random_word();
    gapless = 1'b0;
    pause_for_results();
  endtask

  // Short bursts with a full drain in between, so the engine restarts from idle.
  task automatic test_pause_between_bursts();
    repeat (3) begin
      repeat ($urandom_range(5, 30)) send_random_word();
      pause_for_results();
    end
  endtask

  task automatic test_random_commands(int count);
    repeat (count) send_random_word();
  endtask

  // Predicts on every accepted command word and checks every accepted result word.
  // Both sides are sampled here at the rising edge, command first, so a result can
  // never be checked before its own command has been predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cmd_ch.valid && cmd_ch.ready)
        pending_results.push_back(apply_list_command(cmd_t'(cmd_ch.cmd), cmd_ch.value,
                                                     cmd_ch.position));
      if (rsp_ch.valid && rsp_ch.ready) begin
        result_words++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result word %0d arrived with nothing expected: status %0d found %0b",
                     result_words, rsp_ch.status, rsp_ch.found,
                     " index %0d length %0d", rsp_ch.found_index, rsp_ch.length);
        end else begin
          oldest_result = pending_results.pop_front();
          if (rsp_ch.status !== oldest_result.status || rsp_ch.found !== oldest_result.found ||
              rsp_ch.found_index !== oldest_result.found_index ||
              rsp_ch.length !== oldest_result.length) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("result word %0d: expected status %0d found %0b index %0d length %0d,",
                       result_words, oldest_result.status, oldest_result.found,
                       oldest_result.found_index, oldest_result.length,
                       " got status %0d found %0b index %0d length %0d",
                       rsp_ch.status, rsp_ch.found, rsp_ch.found_index, rsp_ch.length);
          end
        end
      end
    end
  end

  // Result side: each segment holds one randomly picked ready pattern.
  // A hold request overrides the pattern and keeps ready low for a counted stretch.
  initial begin : result_receiver
    rx_mode_t mode;
    int       seg_left;
    int       hold_left;
    mode      = RX_STEADY;
    seg_left  = 0;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = RESULT_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(RX_STEADY, RX_CADENCE));
          seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        case (mode)
          RX_STEADY:  rsp_ch.ready <= 1'b1;
          RX_COIN:    rsp_ch.ready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          // Ready is low whenever the segment counter modulo five is below two.
          default:    rsp_ch.ready <= ((seg_left % 5) >= 2);
        endcase
      end
    end
  end

  // Ends the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("bounded_ordered_list_engine_top test failed");
      $finish;
    end
  end

  initial begin
    cmd_ch.valid    = 1'b0;
    cmd_ch.cmd      = CMD_CLEAR;
    cmd_ch.value    = '0;
    cmd_ch.position = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_cases();
    test_full_list();
    test_result_backpressure();
    test_pause_between_bursts();
    test_random_commands(1400);

    // Let every owed word come back, then watch for stray words a while longer.
    pause_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("bounded_ordered_list_engine_top test passed");
    else
      $display("bounded_ordered_list_engine_top test failed");
    $finish;
  end

endmodule
